### hw/rtl/hetx_pkg.sv
// Package: table geometry, request codes, entry layout and shared types.
package hetx_pkg;

  localparam int TABLE_ENTRIES = 16384;  // power of two
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int CFG_ADDR_W    = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_EXACT_TYPE = CFG_ADDR_W'(0);

  typedef enum logic [1:0] {
    REQ_LOOKUP       = 2'd0,
    REQ_STORE_ALWAYS = 2'd1,
    REQ_STORE_DEPTH  = 2'd2,
    REQ_STORE_EXACT  = 2'd3
  } req_t;

  typedef struct packed {
    logic [63:0] check;
    logic [63:0] entry;
  } slot_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    slot_t             data;
  } wr_t;

  function automatic logic [63:0] pack_entry(
    input logic [1:0]        kind,
    input logic [5:0]        from_sq,
    input logic [5:0]        to_sq,
    input logic [3:0]        flags,
    input logic signed [15:0] score,
    input logic [7:0]        depth,
    input logic [7:0]        age
  );
    pack_entry = {flags, to_sq, from_sq, score, depth, age, 14'd0, kind};
  endfunction

endpackage

### hw/rtl/hetx_in_if.sv
// Interface: request channel.
interface hetx_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [63:0]        key;
  logic [1:0]         entry_kind;
  logic [5:0]         move_from;
  logic [5:0]         move_to;
  logic [3:0]         move_flags;
  logic signed [15:0] score_in;
  logic [7:0]         depth_in;
  logic [7:0]         age_in;

  modport source (
    output valid, req_type, key, entry_kind, move_from, move_to, move_flags,
           score_in, depth_in, age_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, key, entry_kind, move_from, move_to, move_flags,
           score_in, depth_in, age_in,
    output ready
  );
endinterface

### hw/rtl/hetx_out_if.sv
// Interface: result channel.
interface hetx_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               written;
  logic [1:0]         found_kind;
  logic [5:0]         found_from;
  logic [5:0]         found_to;
  logic [3:0]         found_flags;
  logic signed [15:0] found_score;
  logic [7:0]         found_depth;
  logic [7:0]         found_age;

  modport source (
    output valid, hit, written, found_kind, found_from, found_to, found_flags,
           found_score, found_depth, found_age,
    input  ready
  );
  modport sink (
    input  valid, hit, written, found_kind, found_from, found_to, found_flags,
           found_score, found_depth, found_age,
    output ready
  );
endinterface

### hw/rtl/hetx_table.sv
// Slot memory with clearing sweep after reset and write-to-read forwarding.
module hetx_table (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [hetx_pkg::ADDR_W-1:0] rd_addr,
  output hetx_pkg::slot_t        rd_data,
  input  hetx_pkg::wr_t          wr,
  output logic                   busy
);

  logic [127:0] mem [hetx_pkg::TABLE_ENTRIES];

  hetx_pkg::slot_t                 rd_q_r;
  logic [hetx_pkg::ADDR_W-1:0]     rd_addr_r;
  logic                            fwd_valid_r;
  logic [hetx_pkg::ADDR_W-1:0]     fwd_addr_r;
  hetx_pkg::slot_t                 fwd_data_r;
  logic                            clr_r;
  logic [hetx_pkg::ADDR_W-1:0]     clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_idx_r   <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + hetx_pkg::ADDR_W'(1);
        if (clr_idx_r == hetx_pkg::ADDR_W'(hetx_pkg::TABLE_ENTRIES - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (wr.en) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
    if (wr.en) begin
      fwd_addr_r <= wr.addr;
      fwd_data_r <= wr.data;
    end
  end

  // latest write always wins over the registered read
  assign rd_data = (fwd_valid_r && fwd_addr_r == rd_addr_r) ? fwd_data_r : rd_q_r;
  assign busy    = clr_r;

endmodule

### hw/rtl/hashed_entry_table_xor_check_unit.sv
// Top level: XOR-checked hashed entry table with lookup and three store policies.
//
//   channel | ports  | dir | transfer when
//   --------+--------+-----+----------------------------------------------
//   request | in_ch  | in  | in_ch.valid && in_ch.ready
//   result  | out_ch | out | out_ch.valid && out_ch.ready
//   config  | cfg_*  | in  | psel && penable && pwrite (pready always high)
//
// One request per cycle sustained unless a result stalls; each result goes through
// the compare stage to the output register (memory read at the transfer edge, then
// compare and write back through the single write port, with last-write forwarding).
// After reset the table is swept to zero, one slot a cycle, all TABLE_ENTRIES
// (16384) slots, with in_ch.ready low; config writes are taken throughout.
// A stalled result holds the output register and the compare stage behind it.
module hashed_entry_table_xor_check_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  hetx_in_if.sink                           in_ch,
  hetx_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [hetx_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  logic [1:0] exact_code_r;

  logic        s1_valid_r;
  logic [1:0]  s1_req_r;
  logic [63:0] s1_key_r;
  logic [63:0] s1_entry_r;
  logic [1:0]  s1_kind_r;
  logic [7:0]  s1_depth_r;

  logic               out_valid_r;
  logic               hit_r;
  logic               written_r;
  logic [63:0]        found_r;

  hetx_pkg::slot_t rd_data;
  hetx_pkg::wr_t   wr;
  logic            busy;
  logic            in_xfer;
  logic            s1_adv;
  logic            s1_hit;
  logic            s1_go;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == hetx_pkg::REG_EXACT_TYPE) ? {30'd0, exact_code_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exact_code_r <= 2'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == hetx_pkg::REG_EXACT_TYPE) begin
      exact_code_r <= cfg_pwdata[1:0];
    end
  end

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !busy && (!s1_valid_r || s1_adv);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  hetx_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (in_ch.key[hetx_pkg::ADDR_W-1:0]),
    .rd_data (rd_data),
    .wr      (wr),
    .busy    (busy)
  );

  always_comb begin
    s1_hit = 1'b0;
    s1_go  = 1'b0;
    case (hetx_pkg::req_t'(s1_req_r))
      hetx_pkg::REQ_LOOKUP:       s1_hit = (rd_data.check ^ rd_data.entry) == s1_key_r;
      hetx_pkg::REQ_STORE_ALWAYS: s1_go  = 1'b1;
      hetx_pkg::REQ_STORE_DEPTH:  s1_go  = rd_data.entry[31:24] <= s1_depth_r;
      hetx_pkg::REQ_STORE_EXACT:  s1_go  = s1_kind_r == exact_code_r;
      default: begin
        s1_hit = 1'b0;
        s1_go  = 1'b0;
      end
    endcase
  end

  assign wr.en         = s1_adv && s1_go;
  assign wr.addr       = s1_key_r[hetx_pkg::ADDR_W-1:0];
  assign wr.data.check = s1_key_r ^ s1_entry_r;
  assign wr.data.entry = s1_entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req_r   <= in_ch.req_type;
      s1_key_r   <= in_ch.key;
      s1_kind_r  <= in_ch.entry_kind;
      s1_depth_r <= in_ch.depth_in;
      s1_entry_r <= hetx_pkg::pack_entry(in_ch.entry_kind, in_ch.move_from, in_ch.move_to,
                                         in_ch.move_flags, in_ch.score_in, in_ch.depth_in,
                                         in_ch.age_in);
    end
    if (s1_adv) begin
      hit_r     <= s1_hit;
      written_r <= s1_go;
      found_r   <= s1_hit ? rd_data.entry : 64'd0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = hit_r;
  assign out_ch.written     = written_r;
  assign out_ch.found_kind  = found_r[1:0];
  assign out_ch.found_age   = found_r[23:16];
  assign out_ch.found_depth = found_r[31:24];
  assign out_ch.found_score = found_r[47:32];
  assign out_ch.found_from  = found_r[53:48];
  assign out_ch.found_to    = found_r[59:54];
  assign out_ch.found_flags = found_r[63:60];

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready) else $error("request taken during table clear");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r) else $error("accepted request lost before compare");

  a_write_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (s1_adv && s1_req_r != hetx_pkg::REQ_LOOKUP))
    else $error("slot written without a store leaving the compare stage");

  a_hit_xor_written: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(hit_r && written_r)) else $error("result both hit and written");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !hit_r) |-> found_r == 64'd0) else $error("nonzero fields on miss");

endmodule
